// ----- hdl/deq_pkg.sv -----
package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int COUNT_W     = 5;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    localparam logic signed [OUT_WIDTH-1:0] EMPTY_POP_VALUE = -32'sd1;

    typedef struct packed {
        cmd_e                         command;
        logic signed [OUT_WIDTH-1:0]  push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0]  pop_value;
        status_e                      status;
        logic [COUNT_W-1:0]           element_count;
    } rsp_t;

    typedef struct packed {
        logic                    en;
        cmd_e                    command;
        logic [VALUE_WIDTH-1:0]  push_value;
    } cell_ctrl_t;

    function automatic logic signed [OUT_WIDTH-1:0] widen(input logic [VALUE_WIDTH-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(signed'(v));
        return wide[OUT_WIDTH-1:0];
    endfunction

endpackage

// ----- hdl/deq_cell.sv -----
module deq_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  deq_pkg::cell_ctrl_t             ctrl,
    input  logic [deq_pkg::VALUE_WIDTH-1:0] left_data,
    input  logic                            left_occ,
    input  logic [deq_pkg::VALUE_WIDTH-1:0] right_data,
    input  logic                            right_occ,
    output logic [deq_pkg::VALUE_WIDTH-1:0] data,
    output logic                            occ,
    output logic                            tail
);
    import deq_pkg::*;

    logic [VALUE_WIDTH-1:0] data_reg, data_next;
    logic                   occ_reg, occ_next;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctrl.en)
        begin
            case (ctrl.command)
                CMD_PUSH_BACK:
                begin
                    if (!occ_reg && left_occ)
                    begin
                        data_next = ctrl.push_value;
                        occ_next  = 1'b1;
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    data_next = left_data;
                    occ_next  = left_occ;
                end
                CMD_POP_FRONT:
                begin
                    data_next = right_data;
                    occ_next  = right_occ;
                end
                CMD_POP_BACK:
                begin
                    if (occ_reg && !right_occ)
                        occ_next = 1'b0;
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;
    assign tail = occ_reg && !right_occ;

endmodule

// ----- hdl/double_ended_queue_top.sv -----
// Bounded deque of 16 signed 32-bit values held in a row of shifting cells, front at cell 0.
// A command transfers when start is high (busy stays low, so one command every cycle);
// its result appears one cycle later with done high for exactly that cycle and must be
// taken then. Pops of an empty queue return -1 with status 1, pushes on a full queue
// return 0 with status 2; both leave the contents untouched.
module double_ended_queue_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  deq_pkg::cmd_t request,
    output logic          done,
    output deq_pkg::rsp_t result
);
    import deq_pkg::*;

    logic [DEPTH-1:0]       occ_vec;
    logic [DEPTH-1:0]       tail_vec;
    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic [VALUE_WIDTH-1:0] tail_data;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    rsp_t             result_reg, result_next;
    cell_ctrl_t       ctrl;
    logic             accept, empty, full, is_push;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign is_push = request.command inside {CMD_PUSH_BACK, CMD_PUSH_FRONT};

    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
            tail_data = tail_data | (cell_data[i] & {VALUE_WIDTH{tail_vec[i]}});
    end

    always_comb
    begin
        ctrl.command    = request.command;
        ctrl.push_value = request.push_value[VALUE_WIDTH-1:0];
        ctrl.en         = accept && (is_push ? !full : !empty);
    end

    always_comb
    begin
        count_next            = count_reg;
        done_next             = accept;
        result_next           = result_reg;
        if (accept)
        begin
            result_next.pop_value = '0;
            result_next.status    = ST_DONE;
            case (request.command)
                CMD_PUSH_BACK, CMD_PUSH_FRONT:
                begin
                    if (full)
                        result_next.status = ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        result_next.status    = ST_EMPTY;
                        result_next.pop_value = EMPTY_POP_VALUE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        result_next.pop_value = (request.command == CMD_POP_FRONT)
                                              ? widen(cell_data[0]) : widen(tail_data);
                    end
                end
                default:
                begin
                    result_next.status = ST_DONE;
                end
            endcase
            result_next.element_count = COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] l_data, r_data;
        logic                   l_occ, r_occ;

        if (i == 0)
        begin : g_first
            assign l_data = ctrl.push_value;
            assign l_occ  = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data = cell_data[i-1];
            assign l_occ  = occ_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_data = cell_data[i];
            assign r_occ  = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data = cell_data[i+1];
            assign r_occ  = occ_vec[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_data  (l_data),
            .left_occ   (l_occ),
            .right_data (r_data),
            .right_occ  (r_occ),
            .data       (cell_data[i]),
            .occ        (occ_vec[i]),
            .tail       (tail_vec[i])
        );
    end

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count_reg))
        else $error("occupied cells disagree with element count");

    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + DEPTH'(1)) & occ_vec) == '0)
        else $error("occupied cells not packed toward the front");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("transfer without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without transfer");

    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |->
            (result.pop_value == '0 && result.element_count == COUNT_W'(DEPTH)))
        else $error("bad full refusal result");

endmodule

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int RANDOM_ITEMS   = 880;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        cmd_t req;
        bit   typed;
        rsp_t expected;
    } directed_row_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    cmd_t  request;
    logic  done;
    rsp_t  result;

    rsp_t  pending_responses [$];
    rsp_t  oldest_response;
    int    mismatch_count = 0;
    int    stalled_cycles = 0;
    bit    idle_on = 1'b1;

    // deque mirror
    logic [VALUE_WIDTH-1:0] mirror_ring [DEPTH];
    int                     mirror_front = 0;
    int                     mirror_back  = 0;
    int                     mirror_count = 0;

    // front/back extremes, empty pops, last element popped, fill to full, full pushes
    directed_row_t directed_rows [25] = '{
        '{'{CMD_POP_FRONT,  32'sd0},          1'b1, '{EMPTY_POP_VALUE, ST_EMPTY, 5'd0}},
        '{'{CMD_POP_BACK,   32'sh7FFF_FFFF},  1'b1, '{EMPTY_POP_VALUE, ST_EMPTY, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'sh7FFF_FFFF},  1'b1, '{32'sd0, ST_DONE, 5'd1}},
        '{'{CMD_PUSH_FRONT, 32'sh8000_0000},  1'b1, '{32'sd0, ST_DONE, 5'd2}},
        '{'{CMD_POP_BACK,   32'sd0},          1'b1, '{32'sh7FFF_FFFF, ST_DONE, 5'd1}},
        '{'{CMD_POP_FRONT,  32'shFFFF_FFFF},  1'b1, '{32'sh8000_0000, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'sh0000_0001},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'sh5555_5555},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'shAAAA_AAAA},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'sh0F0F_0F0F},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'shF0F0_F0F0},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'sh0000_FFFF},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'shFFFF_0000},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'sh1234_5678},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'shFEDC_BA98},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'shFFFF_FFFE},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'sh4000_0000},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'shBFFF_FFFF},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'sh0000_0080},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'sh7FFF_FFFE},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'sh8000_0001},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_FRONT, 32'sh0000_0002},  1'b0, '{32'sd0, ST_DONE, 5'd0}},
        '{'{CMD_PUSH_BACK,  32'sh7FFF_FFFF},  1'b1, '{32'sd0, ST_FULL, 5'd16}},
        '{'{CMD_PUSH_FRONT, 32'sh8000_0000},  1'b1, '{32'sd0, ST_FULL, 5'd16}},
        '{'{CMD_POP_FRONT,  32'sd0},          1'b0, '{32'sd0, ST_DONE, 5'd0}}
    };

    double_ended_queue_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #4ns clk = ~clk;

    function automatic int slot_after(input int slot);
        return (slot == DEPTH - 1) ? 0 : slot + 1;
    endfunction

    function automatic int slot_before(input int slot);
        return (slot == 0) ? DEPTH - 1 : slot - 1;
    endfunction

    function automatic rsp_t predict_deque_response(input cmd_t req);
        rsp_t rsp;
        rsp = '{32'sd0, ST_DONE, 5'd0};
        case (req.command)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (mirror_count >= DEPTH)
                begin
                    rsp.status = ST_FULL;
                end
                else if (req.command == CMD_PUSH_BACK)
                begin
                    mirror_ring[mirror_back] = req.push_value[VALUE_WIDTH-1:0];
                    mirror_back = slot_after(mirror_back);
                    mirror_count++;
                end
                else
                begin
                    mirror_front = slot_before(mirror_front);
                    mirror_ring[mirror_front] = req.push_value[VALUE_WIDTH-1:0];
                    mirror_count++;
                end
            end
            default:
            begin
                if (mirror_count == 0)
                begin
                    rsp.status    = ST_EMPTY;
                    rsp.pop_value = EMPTY_POP_VALUE;
                end
                else if (req.command == CMD_POP_FRONT)
                begin
                    rsp.pop_value = OUT_WIDTH'(signed'(mirror_ring[mirror_front]));
                    mirror_front = slot_after(mirror_front);
                    mirror_count--;
                end
                else
                begin
                    mirror_back = slot_before(mirror_back);
                    rsp.pop_value = OUT_WIDTH'(signed'(mirror_ring[mirror_back]));
                    mirror_count--;
                end
            end
        endcase
        rsp.element_count = COUNT_W'(mirror_count);
        return rsp;
    endfunction

    // call right after a rising edge; returns at the edge that takes the transfer
    task automatic issue_command(input cmd_t req, input bit typed, input rsp_t typed_rsp);
        rsp_t predicted;
        if (idle_on && $urandom_range(99) < 33)
        begin
            start <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
        predicted = predict_deque_response(req);
        pending_responses.push_back(typed ? typed_rsp : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response with nothing expected: value %h status %0d count %0d",
                         $time, result.pop_value, result.status, result.element_count);
                mismatch_count++;
            end
            else
            begin
                oldest_response = pending_responses.pop_front();
                if (result.pop_value !== oldest_response.pop_value)
                begin
                    $display("%0t: pop_value expected %h actual %h",
                             $time, oldest_response.pop_value, result.pop_value);
                    mismatch_count++;
                end
                if (result.status !== oldest_response.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_response.status, result.status);
                    mismatch_count++;
                end
                if (result.element_count !== oldest_response.element_count)
                begin
                    $display("%0t: element_count expected %0d actual %0d",
                             $time, oldest_response.element_count, result.element_count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial
    begin
        cmd_t req;
        int   bias;
        int   push_odds;
        bit   is_pop;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '{CMD_PUSH_BACK, 32'sd0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            issue_command(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].expected);
        end

        // phases lean toward filling, draining or neither so full and empty recur
        bias = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 48 == 0)
            begin
                bias = $urandom_range(2);
            end
            push_odds = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
            idle_on   = !(n >= 300 && n < 500);
            is_pop    = ($urandom_range(99) >= push_odds);
            req.command = cmd_e'({is_pop, 1'($urandom_range(1))});
            case ($urandom_range(15))
                0:       req.push_value = 32'sh7FFF_FFFF;
                1:       req.push_value = 32'sh8000_0000;
                2:       req.push_value = -32'sd1;
                3:       req.push_value = 32'sd0;
                default: req.push_value = $urandom;
            endcase
            issue_command(req, 1'b0, '{32'sd0, ST_DONE, 5'd0});
        end

        start <= 1'b0;
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue_top.sv
dv/tb.sv
